[rtl/snx3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snx3_pkg
// Shared constants, permutation ROM and gradient selection for the 3D
// simplex noise unit.
// ----------------------------------------------------------------------------
package snx3_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int PERM_ENTRIES  = 256;
   localparam int GRAD_COUNT    = 12;
   localparam int STAGES        = 15;

   // falloff radius squared, 0.6 in Q.30
   localparam logic [33:0] Q30_SIX_TENTHS = 34'd644245094;

   typedef enum logic [3:0] {
      G_PP0, G_NP0, G_PN0, G_NN0,
      G_P0P, G_N0P, G_P0N, G_N0N,
      G_0PP, G_0NP, G_0PN, G_0NN
   } grad_type;

   typedef logic [7:0] perm_rom_type [PERM_ENTRIES];
   typedef grad_type   grad_rom_type [PERM_ENTRIES];

   localparam perm_rom_type PERM_ROM = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
      8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
      8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
      8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
      8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
      8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
      8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
      8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
      8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
      8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
      8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
      8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
      8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
      8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
      8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
      8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
      8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
      8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
      8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
      8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
      8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
      8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
      8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
      8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
      8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
      8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
      8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
      8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
      8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
      8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
      8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
      8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
   };

   function automatic grad_rom_type build_grad_rom();
      grad_rom_type tab;
      for (int i = 0; i < PERM_ENTRIES; i++) begin
         tab[i] = grad_type'(4'(PERM_ROM[i] % GRAD_COUNT));
      end
      return tab;
   endfunction

   // permutation entry folded straight to its gradient
   localparam grad_rom_type GRAD_ROM = build_grad_rom();

endpackage

[rtl/snx3_corner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snx3_corner
// Falloff and gradient contribution of one simplex corner, five stages:
// squares and dot, radius test, t^2, t^4, t^4 * dot.
// ----------------------------------------------------------------------------
module snx3_corner (
   input  logic                      clock,
   input  logic [4:0]                en,
   input  logic signed [31:0]        q [3],
   input  snx3_pkg::grad_type        grad,
   output logic signed [34:0]        contrib
);
   import snx3_pkg::*;

   function automatic logic signed [33:0] grad_dot(grad_type g, logic signed [33:0] x,
                                                   logic signed [33:0] y,
                                                   logic signed [33:0] z);
      logic signed [33:0] r;
      unique case (g)
         G_PP0:   r =  x + y;
         G_NP0:   r = -x + y;
         G_PN0:   r =  x - y;
         G_NN0:   r = -x - y;
         G_P0P:   r =  x + z;
         G_N0P:   r = -x + z;
         G_P0N:   r =  x - z;
         G_N0N:   r = -x - z;
         G_0PP:   r =  y + z;
         G_0NP:   r = -y + z;
         G_0PN:   r =  y - z;
         G_0NN:   r = -y - z;
         default: r = '0;
      endcase
      return r;
   endfunction

   logic signed [63:0] sq_in [3];
   logic signed [63:0] sq_ff [3];
   logic signed [33:0] dot_in, dot_ff, dot9_ff, dot10_ff, dot11_ff;
   logic [63:0]        r2sum;
   logic [33:0]        r2;
   logic [29:0]        t_in, t_ff;
   logic [59:0]        tt_in, tt_ff;
   logic [59:0]        t2sq;
   logic [29:0]        t4_in, t4_ff;
   logic signed [64:0] cprod;
   logic signed [34:0] contrib_in, contrib_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = q[k] * q[k];
      end
      dot_in = grad_dot(grad, 34'(q[0]), 34'(q[1]), 34'(q[2]));
      r2sum  = 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]);
      r2     = r2sum[63:30];
      // outside the radius: zero t drives the whole term to zero
      t_in   = (r2 < Q30_SIX_TENTHS) ? 30'(Q30_SIX_TENTHS - r2) : '0;
      tt_in  = 60'(t_ff) * 60'(t_ff);
      t2sq   = 60'(tt_ff[59:30]) * 60'(tt_ff[59:30]);
      t4_in  = t2sq[59:30];
      cprod  = $signed({1'b0, t4_ff}) * dot11_ff;
      contrib_in = cprod[64:30];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sq_ff  <= sq_in;
         dot_ff <= dot_in;
      end
      if (en[1]) begin
         t_ff    <= t_in;
         dot9_ff <= dot_ff;
      end
      if (en[2]) begin
         tt_ff    <= tt_in;
         dot10_ff <= dot9_ff;
      end
      if (en[3]) begin
         t4_ff    <= t4_in;
         dot11_ff <= dot10_ff;
      end
      if (en[4]) begin
         contrib_ff <= contrib_in;
      end
   end

   assign contrib = contrib_ff;

endmodule

[rtl/simplex_noise_3d_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simplex_noise_3d_unit
// 3D simplex noise of a fixed-point point, one sample per item, Q1.15 out.
// ----------------------------------------------------------------------------
// Pipeline: 15 register stages.
// Throughput: one item per cycle while the output side does not stall; each
//   stage moves on its own, so bubbles close up behind a stalled output.
// Reset clears the stage valid bits only; no table or datapath state.
module simplex_noise_3d_unit #(
   parameter int FRAC_BITS = snx3_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_noise_value
);
   import snx3_pkg::*;

   localparam int NW = 35;
   localparam int MW = NW - FRAC_BITS;
   localparam int UW = MW + 1;
   localparam int K3 = UW + 1;
   localparam logic [UW-1:0] R3 = UW'(((64'd1 << K3) + 64'd2) / 64'd3);
   localparam logic [UW-1:0] BU = UW'(64'd3 << (MW - 1));
   localparam int XW = FRAC_BITS + 5;
   localparam int HW = XW - FRAC_BITS;
   localparam int K6 = XW + 2;
   localparam logic [XW:0]   R6 = (XW + 1)'(((64'd1 << K6) + 64'd2) / 64'd3);
   localparam logic [XW+1:0] B6 = (XW + 2)'(64'd3 << XW);
   localparam int S = 30 - FRAC_BITS;
   localparam logic [XW-1:0] ONE_X   = XW'(64'd1 << FRAC_BITS);
   localparam logic [XW-1:0] TWO_X   = XW'(64'd2 << FRAC_BITS);
   localparam logic [XW-1:0] THREE_X = XW'(64'd3 << FRAC_BITS);
   localparam logic [XW-1:0] SIX_X   = XW'(64'd6 << FRAC_BITS);
   localparam logic [31:0] SIXTH_TAB [8] = '{
      32'd0,
      32'((64'd1 << S) / 64'd6), 32'((64'd2 << S) / 64'd6),
      32'((64'd3 << S) / 64'd6), 32'((64'd4 << S) / 64'd6),
      32'((64'd5 << S) / 64'd6), 32'd0, 32'd0
   };

   // stage valids and per-stage advance
   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] en;

   always_comb begin
      en[STAGES-1] = !v_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_valid;
         for (int k = 1; k < STAGES; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[STAGES-1];

   // stage 0: input register
   logic signed [31:0] c_ff [3];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         c_ff[0] <= req_coord_x;
         c_ff[1] <= req_coord_y;
         c_ff[2] <= req_coord_z;
      end
   end

   // stage 1: skewed numerator, floor by the fraction, bias for divide by 3
   logic signed [33:0]   sum1;
   logic signed [NW-1:0] n1 [3];
   logic [UW-1:0]        u1_in [3], u1_ff [3];
   logic [XW-1:0]        cx1_in [3], cx1_ff [3];

   always_comb begin
      sum1 = 34'(c_ff[0]) + 34'(c_ff[1]) + 34'(c_ff[2]);
      for (int k = 0; k < 3; k++) begin
         n1[k]     = (NW'(c_ff[k]) <<< 1) + NW'(c_ff[k]) + NW'(sum1);
         u1_in[k]  = {n1[k][NW-1], n1[k][NW-1:FRAC_BITS]} + BU;
         cx1_in[k] = c_ff[k][XW-1:0];
      end
   end

   // stage 2: reciprocal multiply
   logic [2*UW-1:0] prod2_in [3], prod2_ff [3];
   logic [XW-1:0]   cx2_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod2_in[k] = (2 * UW)'(u1_ff[k]) * (2 * UW)'(R3);
      end
   end

   // stage 3: cell coordinate, bias removed by flipping the top bit
   logic [MW-1:0] cell3_in [3], cell3_ff [3];
   logic [XW-1:0] cx3_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cell3_in[k] = {~prod2_ff[k][2*UW-1], prod2_ff[k][2*UW-2:K3]};
      end
   end

   // stage 4: unskewed offset of corner zero, in 1/6 fraction units
   logic [HW-1:0]        isum4;
   logic [HW-1:0]        hi4 [3];
   logic signed [XW-1:0] x0_in [3], x0_ff [3];
   logic [7:0]           hc4_in [3], hc4_ff [3];

   always_comb begin
      isum4 = cell3_ff[0][HW-1:0] + cell3_ff[1][HW-1:0] + cell3_ff[2][HW-1:0];
      for (int k = 0; k < 3; k++) begin
         hi4[k]    = isum4 - HW'(cell3_ff[k][HW-1:0] * HW'(6));
         x0_in[k]  = XW'(cx3_ff[k] * XW'(6)) + {hi4[k], {FRAC_BITS{1'b0}}};
         hc4_in[k] = cell3_ff[k][7:0];
      end
   end

   // stage 5: corner order, corner offsets, first hash level
   logic [2:0]    a1, a2;
   logic [2:0]    av [4];
   logic [XW-1:0] off5_in [4][3], off5_ff [4][3];
   logic [7:0]    p1_in [4], p1_ff [4];
   logic [7:0]    hy5_in [4], hy5_ff [4];
   logic [7:0]    hx5_in [4], hx5_ff [4];

   always_comb begin
      priority if (x0_ff[0] >= x0_ff[1]) begin
         priority if (x0_ff[1] >= x0_ff[2]) begin
            a1 = 3'b001; a2 = 3'b011;
         end else if (x0_ff[0] >= x0_ff[2]) begin
            a1 = 3'b001; a2 = 3'b101;
         end else begin
            a1 = 3'b100; a2 = 3'b101;
         end
      end else begin
         priority if (x0_ff[1] < x0_ff[2]) begin
            a1 = 3'b100; a2 = 3'b110;
         end else if (x0_ff[0] < x0_ff[2]) begin
            a1 = 3'b010; a2 = 3'b110;
         end else begin
            a1 = 3'b010; a2 = 3'b011;
         end
      end
      av[0] = 3'b000;
      av[1] = a1;
      av[2] = a2;
      av[3] = 3'b111;
      for (int k = 0; k < 3; k++) begin
         off5_in[0][k] = x0_ff[k];
         off5_in[1][k] = x0_ff[k] - (a1[k] ? SIX_X : '0) + ONE_X;
         off5_in[2][k] = x0_ff[k] - (a2[k] ? SIX_X : '0) + TWO_X;
         off5_in[3][k] = x0_ff[k] - THREE_X;
      end
      for (int c = 0; c < 4; c++) begin
         p1_in[c]  = PERM_ROM[hc4_ff[2] + {7'd0, av[c][2]}];
         hy5_in[c] = hc4_ff[1] + {7'd0, av[c][1]};
         hx5_in[c] = hc4_ff[0] + {7'd0, av[c][0]};
      end
   end

   // stage 6: second hash level, offset divide by 6 (reciprocal multiply)
   logic [XW+1:0]     uo6 [4][3];
   logic [2*XW+1:0]   prod6_in [4][3], prod6_ff [4][3];
   logic [2:0]        b6_in [4][3], b6_ff [4][3];
   logic [7:0]        p2_in [4], p2_ff [4];
   logic [7:0]        hx6_ff [4];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         p2_in[c] = PERM_ROM[hy5_ff[c] + p1_ff[c]];
         for (int k = 0; k < 3; k++) begin
            uo6[c][k] = {{2{off5_ff[c][k][XW-1]}}, off5_ff[c][k]} + B6;
            prod6_in[c][k] = (2 * XW + 2)'(uo6[c][k][XW+1:1]) * (2 * XW + 2)'(R6);
            b6_in[c][k] = uo6[c][k][2:0];
         end
      end
   end

   // stage 7: gradient pick, offsets to Q2.30
   logic [XW-1:0]        quot7 [4][3];
   logic signed [XW-1:0] a7 [4][3];
   logic [2:0]           b7 [4][3];
   logic signed [31:0]   q7_in [4][3], q7_ff [4][3];
   grad_type             g7_in [4], g7_ff [4];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         g7_in[c] = GRAD_ROM[hx6_ff[c] + p2_ff[c]];
         for (int k = 0; k < 3; k++) begin
            quot7[c][k] = prod6_ff[c][k][2*XW+1:K6];
            a7[c][k]    = {~quot7[c][k][XW-1], quot7[c][k][XW-2:0]};
            b7[c][k]    = b6_ff[c][k] - 3'(quot7[c][k][2:0] * 3'd6);
            q7_in[c][k] = (32'(a7[c][k]) << S) + SIXTH_TAB[b7[c][k]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         u1_ff  <= u1_in;
         cx1_ff <= cx1_in;
      end
      if (en[2]) begin
         prod2_ff <= prod2_in;
         cx2_ff   <= cx1_ff;
      end
      if (en[3]) begin
         cell3_ff <= cell3_in;
         cx3_ff   <= cx2_ff;
      end
      if (en[4]) begin
         x0_ff  <= x0_in;
         hc4_ff <= hc4_in;
      end
      if (en[5]) begin
         off5_ff <= off5_in;
         p1_ff   <= p1_in;
         hy5_ff  <= hy5_in;
         hx5_ff  <= hx5_in;
      end
      if (en[6]) begin
         prod6_ff <= prod6_in;
         b6_ff    <= b6_in;
         p2_ff    <= p2_in;
         hx6_ff   <= hx5_ff;
      end
      if (en[7]) begin
         q7_ff <= q7_in;
         g7_ff <= g7_in;
      end
   end

   // stages 8 to 12: one falloff pipe per corner
   logic signed [34:0] contrib [4];

   for (genvar c = 0; c < 4; c++) begin : g_corner
      snx3_corner u_corner (
         .clock   (clock),
         .en      (en[12:8]),
         .q       (q7_ff[c]),
         .grad    (g7_ff[c]),
         .contrib (contrib[c])
      );
   end

   // stage 13: corner sum; stage 14: scale and saturate
   logic signed [36:0] total_in, total_ff;
   logic signed [26:0] scaled;
   logic signed [15:0] noise_in, noise_ff;

   always_comb begin
      total_in = 37'(contrib[0]) + 37'(contrib[1]) + 37'(contrib[2]) + 37'(contrib[3]);
      scaled   = total_ff[36:10];
      priority if (scaled > 27'sd32767) begin
         noise_in = 16'sh7fff;
      end else if (scaled < -27'sd32768) begin
         noise_in = -16'sh8000;
      end else begin
         noise_in = scaled[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[13]) total_ff <= total_in;
      if (en[14]) noise_ff <= noise_in;
   end

   assign rsp_noise_value = noise_ff;

   // the input side only stalls when every stage holds an item
   assert property (@(posedge clock) disable iff (reset) req_stall |-> (&v_ff))
      else $error("input stalled with a free stage");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
                    (v_ff[STAGES-2] && en[STAGES-1]) |=> rsp_valid)
      else $error("item lost entering the output stage");

endmodule

[tb/noise_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noise_checker
// Watches both channels of the simplex noise unit, predicts each sample in
// wide exact integer arithmetic and compares it with the returned value.
// ----------------------------------------------------------------------------
module noise_checker #(
   parameter int FRAC_BITS = snx3_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_noise_value,
   output int                 fail_count,
   output int                 pending_count,
   output int                 sample_count,
   output int                 clip_count
);
   import snx3_pkg::*;

   localparam longint SIX_TENTHS = 64'sd644245094;

   logic signed [15:0] noise_queue [$];

   function automatic longint div_floor(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic int pick_grad(longint cx, longint cy, longint cz,
                                    int ax, int ay, int az);
      logic [7:0] p;
      p = PERM_ROM[8'(cz[7:0] + ax[7:0] - ax[7:0] + az[7:0])];
      p = PERM_ROM[8'(cy[7:0] + ay[7:0] + p)];
      p = PERM_ROM[8'(cx[7:0] + ax[7:0] + p)];
      return int'(p) % GRAD_COUNT;
   endfunction

   function automatic longint falloff_term(longint ox, longint oy, longint oz, int g);
      longint q [3];
      longint o [3];
      longint r2, t, t2, t4, dotp;
      int gv [3];
      o[0] = ox; o[1] = oy; o[2] = oz;
      case (grad_type'(g))
         G_PP0: gv = '{1, 1, 0};   G_NP0: gv = '{-1, 1, 0};
         G_PN0: gv = '{1, -1, 0};  G_NN0: gv = '{-1, -1, 0};
         G_P0P: gv = '{1, 0, 1};   G_N0P: gv = '{-1, 0, 1};
         G_P0N: gv = '{1, 0, -1};  G_N0N: gv = '{-1, 0, -1};
         G_0PP: gv = '{0, 1, 1};   G_0NP: gv = '{0, -1, 1};
         G_0PN: gv = '{0, 1, -1};  default: gv = '{0, -1, -1};
      endcase
      r2 = 0; dotp = 0;
      for (int k = 0; k < 3; k++) begin
         q[k] = div_floor(o[k] * (64'sd1 <<< (30 - FRAC_BITS)), 6);
         r2 += q[k] * q[k];
         dotp += gv[k] * q[k];
      end
      r2 = r2 >>> 30;
      t = SIX_TENTHS - r2;
      if (t <= 0) return 0;
      t2 = (t * t) >>> 30;
      t4 = (t2 * t2) >>> 30;
      return (t4 * dotp) >>> 30;
   endfunction

   function automatic logic signed [15:0] noise_at(longint x, longint y, longint z);
      longint one, s, isum, total, res;
      longint c [3];
      longint lat [3];
      longint x0 [3];
      int a1 [3];
      int a2 [3];
      one = 64'sd1 <<< FRAC_BITS;
      c[0] = x; c[1] = y; c[2] = z;
      s = x + y + z;
      for (int k = 0; k < 3; k++) lat[k] = div_floor(3 * c[k] + s, 3 * one);
      isum = lat[0] + lat[1] + lat[2];
      for (int k = 0; k < 3; k++) x0[k] = 6 * c[k] - 6 * lat[k] * one + isum * one;
      a1 = '{0, 0, 0}; a2 = '{0, 0, 0};
      if (x0[0] >= x0[1]) begin
         if (x0[1] >= x0[2]) begin a1[0] = 1; a2[0] = 1; a2[1] = 1; end
         else if (x0[0] >= x0[2]) begin a1[0] = 1; a2[0] = 1; a2[2] = 1; end
         else begin a1[2] = 1; a2[0] = 1; a2[2] = 1; end
      end else begin
         if (x0[1] < x0[2]) begin a1[2] = 1; a2[1] = 1; a2[2] = 1; end
         else if (x0[0] < x0[2]) begin a1[1] = 1; a2[1] = 1; a2[2] = 1; end
         else begin a1[1] = 1; a2[0] = 1; a2[1] = 1; end
      end
      total = falloff_term(x0[0], x0[1], x0[2],
                           pick_grad(lat[0], lat[1], lat[2], 0, 0, 0));
      total += falloff_term(x0[0] - 6 * one * a1[0] + one, x0[1] - 6 * one * a1[1] + one,
                            x0[2] - 6 * one * a1[2] + one,
                            pick_grad(lat[0], lat[1], lat[2], a1[0], a1[1], a1[2]));
      total += falloff_term(x0[0] - 6 * one * a2[0] + 2 * one,
                            x0[1] - 6 * one * a2[1] + 2 * one,
                            x0[2] - 6 * one * a2[2] + 2 * one,
                            pick_grad(lat[0], lat[1], lat[2], a2[0], a2[1], a2[2]));
      total += falloff_term(x0[0] - 3 * one, x0[1] - 3 * one, x0[2] - 3 * one,
                            pick_grad(lat[0], lat[1], lat[2], 1, 1, 1));
      res = total >>> 10;
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      return 16'(res);
   endfunction

   assign pending_count = noise_queue.size();

   always @(posedge clock) begin
      logic signed [15:0] want;
      if (reset) begin
         fail_count <= 0;
         sample_count <= 0;
         clip_count <= 0;
         noise_queue.delete();
      end else begin
         if (req_valid && !req_stall) begin
            want = noise_at(req_coord_x, req_coord_y, req_coord_z);
            noise_queue.push_back(want);
            if (want == 16'sh7fff || want == -16'sh8000) clip_count <= clip_count + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            sample_count <= sample_count + 1;
            if (noise_queue.size() == 0) begin
               $error("noise_value: unexpected item, actual %0d", rsp_noise_value);
               fail_count <= fail_count + 1;
            end else begin
               want = noise_queue.pop_front();
               if (rsp_noise_value !== want) begin
                  $error("noise_value: expected %0d, actual %0d", want, rsp_noise_value);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random points into the simplex noise unit with random
// gaps and output stalls; the checker predicts and compares every sample.
// ----------------------------------------------------------------------------
module testbench;

   localparam int ITEM_COUNT = 600;
   localparam int IDLE_LIMIT = 2000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_coord_x;
   logic signed [31:0] req_coord_y;
   logic signed [31:0] req_coord_z;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_noise_value;
   int                 fail_count;
   int                 pending_count;
   int                 sample_count;
   int                 clip_count;
   int                 idle_cycles;
   logic               calm;

   simplex_noise_3d_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .req_coord_z(req_coord_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_noise_value(rsp_noise_value)
   );

   noise_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .req_coord_z(req_coord_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_noise_value(rsp_noise_value),
      .fail_count(fail_count), .pending_count(pending_count),
      .sample_count(sample_count), .clip_count(clip_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // output stalls at random, except in the calm stretch
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 14);
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL simplex_noise_3d_unit");
            $finish;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the accept
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      while (!calm && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(4))
         0: return $urandom();
         1: return 32'($signed($urandom_range(2000000)) - 1000000);
         2: return 32'($signed($urandom_range(131072)) - 65536);
         3: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
         default: return 32'($urandom_range(255)) << 16;
      endcase
   endfunction

   initial begin
      logic [31:0] extremes [6];
      extremes = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                   32'h0001_0000, 32'h00ff_8000};
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_coord_x = '0;
      req_coord_y = '0;
      req_coord_z = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes, lattice points, wrap and tie cases
      for (int i = 0; i < 6; i++)
         send_point(extremes[i], extremes[(i + 1) % 6], extremes[(i + 3) % 6]);
      send_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
      send_point(32'h0000_4000, 32'h0000_4000, 32'h0000_0000);
      send_point(32'h0100_0000, 32'hff00_0000, 32'h0000_2000);
      send_point(32'h0000_1000, 32'h0000_3000, 32'h0000_2000);
      send_point(32'h0000_3000, 32'h0000_1000, 32'h0000_2000);
      send_point(32'h0000_2000, 32'h0000_3000, 32'h0000_1000);
      send_point(32'h0000_2000, 32'h0000_1000, 32'h0000_3000);
      send_point(32'h0000_1000, 32'h0000_2000, 32'h0000_3000);
      send_point(32'h0000_3000, 32'h0000_2000, 32'h0000_1000);
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);

      for (int n = 0; n < ITEM_COUNT; n++) begin
         calm = (n >= 250 && n < 350);
         send_point(random_coord(), random_coord(), random_coord());
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("Sent %0d points (directed extremes, tie orderings, random spread);",
               ITEM_COUNT + 18);
      $display("checked %0d samples, %0d of them saturated.", sample_count, clip_count);
      if (fail_count == 0)
         $display("PASS simplex_noise_3d_unit");
      else
         $display("FAIL simplex_noise_3d_unit");
      $finish;
   end

endmodule
